@@ rtl/core/qsg_pkg.sv @@
// qsg_pkg: shared types, constants and arithmetic helpers of the state-vector gate engine
// no dependencies; imported by every module in rtl/core
package qsg_pkg;

    localparam int AMP_W     = 18;
    localparam int QIDX_W    = 4;
    localparam int MASK_W    = 10;
    localparam int ANGLE_W   = 18;
    localparam int EXP_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 10;
    localparam int ZW        = 28;
    localparam int PW        = 48;
    localparam int QDEPTH    = 2;
    localparam int CORDIC_STEPS = 24;

    localparam logic signed [AMP_W-1:0] AMP_MAX = 18'sd131071;
    localparam logic signed [AMP_W-1:0] AMP_MIN = -18'sd131072;
    localparam logic signed [ZW-1:0] HALF_SQRT   = 28'sd11863283;
    localparam logic signed [ZW-1:0] CORDIC_GAIN = 28'sd10188014;
    localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [EXP_W-1:0] EXP_ONE  = 32'sd1073741824;

    localparam logic [CFG_IDX_W-1:0] CFG_QUBIT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_MASK    = 1'd1;

    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_H     = 3'd1,
        ACT_RZ    = 3'd2,
        ACT_CX    = 3'd3,
        ACT_MEAS  = 3'd4
    } t_action;

    typedef struct packed {
        t_action                op;
        logic [QIDX_W-1:0]      q0;
        logic [QIDX_W-1:0]      q1;
        logic signed [ZW-1:0]   h;
        logic                   neg;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
        logic signed [ZW-1:0] t;
        case (i)
            5'd0:    t = 28'sd13176795;
            5'd1:    t = 28'sd7778716;
            5'd2:    t = 28'sd4110060;
            5'd3:    t = 28'sd2086331;
            5'd4:    t = 28'sd1047214;
            5'd5:    t = 28'sd524117;
            5'd6:    t = 28'sd262123;
            5'd7:    t = 28'sd131069;
            5'd8:    t = 28'sd65536;
            default: t = ZW'(1) <<< (5'd24 - i);
        endcase
        return t;
    endfunction

    // round half up at 2^24, then saturate to the amplitude range
    function automatic logic signed [AMP_W-1:0] rnd_sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = (v + $signed(PW'(24'h800000))) >>> 24;
        if (r > PW'(AMP_MAX))
            return AMP_MAX;
        else if (r < PW'(AMP_MIN))
            return AMP_MIN;
        return r[AMP_W-1:0];
    endfunction

endpackage

@@ rtl/core/qsg_queue.sv @@
// qsg_queue: short fifo of classified items between front and back
// depends on qsg_pkg (t_entry, QDEPTH)
module qsg_queue import qsg_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_entry o_pop_entry,
    input  logic   i_pop_ready
);

    localparam int IW = $clog2(QDEPTH);

    t_entry          r_mem [QDEPTH];
    logic [IW-1:0]   r_wp, r_rp;
    logic [IW:0]     r_cnt;
    logic            push, pop;

    assign o_push_ready = (r_cnt != (IW+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_entry  = r_mem[r_rp];
    assign push = i_push.valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (32'(r_wp) == QDEPTH-1) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (32'(r_rp) == QDEPTH-1) ? '0 : r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/core/qsg_front.sv @@
// qsg_front: accepts input beats, drops items that change nothing, folds the rz half angle
// depends on qsg_pkg (t_action, t_entry, t_push)
module qsg_front import qsg_pkg::*; #(
    parameter  int MAX_QUBITS = 10,
    localparam int NW = $clog2(MAX_QUBITS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2:0]                i_action,
    input  logic [QIDX_W-1:0]         i_first_qubit,
    input  logic [QIDX_W-1:0]         i_second_qubit,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic [NW-1:0]             i_n,
    output t_push                     o_push,
    input  logic                      i_push_ready
);

    logic                 r_v;
    t_entry               r_e;
    logic                 keep;
    logic                 q0_ok, q1_ok;
    logic signed [ZW-1:0] h_raw;
    t_entry               n_e;

    assign o_ready = !r_v || i_push_ready;
    assign o_push  = '{valid: r_v, entry: r_e};

    always_comb begin
        q0_ok = 32'(i_first_qubit) < 32'(i_n);
        q1_ok = 32'(i_second_qubit) < 32'(i_n);
        // theta/2 in q.24 is the q3.14 angle times 512
        h_raw = ZW'(i_angle) <<< 9;
        n_e.op  = t_action'(i_action);
        n_e.q0  = i_first_qubit;
        n_e.q1  = i_second_qubit;
        n_e.h   = h_raw;
        n_e.neg = 1'b0;
        if (h_raw > HALF_PI_Q24) begin
            n_e.h   = h_raw - PI_Q24;
            n_e.neg = 1'b1;
        end else if (h_raw < -HALF_PI_Q24) begin
            n_e.h   = h_raw + PI_Q24;
            n_e.neg = 1'b1;
        end
        case (i_action)
            ACT_START, ACT_MEAS: keep = 1'b1;
            ACT_H, ACT_RZ:       keep = q0_ok;
            ACT_CX:              keep = q0_ok && q1_ok && (i_first_qubit != i_second_qubit);
            default:             keep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_e <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_v <= keep;
        end else if (i_push_ready) begin
            r_v <= 1'b0;
        end
    end

endmodule

@@ rtl/core/qsg_back.sv @@
// qsg_back: amplitude memory, cordic and the sweep pipeline that runs each gate or measure
// depends on qsg_pkg (types, constants, atan_step, rnd_sat)
module qsg_back import qsg_pkg::*; #(
    parameter  int MAX_QUBITS = 10,
    localparam int NW = $clog2(MAX_QUBITS + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [NW-1:0]           i_n,
    input  logic [MASK_W-1:0]       i_mask,
    input  logic                    i_q_valid,
    input  t_entry                  i_q_entry,
    output logic                    o_q_ready,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [EXP_W-1:0] o_expectation
);

    localparam int AW    = MAX_QUBITS;
    localparam int CW    = AW + 1;
    localparam int DEPTH = 1 << AW;
    localparam int ACW   = 38 + AW;
    localparam int DW    = 2 * AMP_W;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CORDIC = 6'b000100,
        S_SWEEP  = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    logic [DW-1:0] r_mem [DEPTH];

    t_state               r_state;
    t_action              r_op;
    logic [AW-1:0]        r_m, r_cm;
    logic [CW-1:0]        r_cnt, r_total;
    logic signed [ZW-1:0] r_x, r_y, r_z, r_c, r_s;
    logic [4:0]           r_step;
    logic                 r_neg;

    logic                 r_p1_v, r_p1_b;
    logic [AW-1:0]        r_p1_i, r_p1_j;
    logic [DW-1:0]        r_rd0, r_rd1;

    logic                 r_p2_v, r_p2_b;
    logic [AW-1:0]        r_p2_i, r_p2_j;
    logic signed [PW-1:0] r_pa, r_pb, r_pc, r_pd;
    logic [DW-1:0]        r_sw0, r_sw1;

    logic                 r_p3_v;
    logic [AW-1:0]        r_p3_j;
    logic [DW-1:0]        r_p3_d;

    logic signed [ACW-1:0]   r_acc;
    logic                    r_out_v;
    logic signed [EXP_W-1:0] r_out;

    logic                 pair, issue, bit_i;
    logic [AW-1:0]        c_pair, low, high, idx_i, idx_j, mask_ext, m_lo;
    logic signed [ZW-1:0] dx, dy, tz, nx, ny, nz, sg;
    logic signed [AMP_W-1:0] xr, xi, yr, yi;
    logic signed [ZW-1:0] ma_a, mb_a, ma_b, mb_b, ma_c, mb_c, ma_d, mb_d;
    logic signed [2*ZW-1:0] pr_a, pr_b, pr_c, pr_d;
    logic [DW-1:0]        wi, wj;
    logic signed [PW-1:0] pw_sum;
    logic signed [ACW-1:0] acc_add, acc_rnd;
    logic                 we;
    logic [AW-1:0]        wa;
    logic [DW-1:0]        wd;
    logic [AW-1:0]        m_new;
    logic [AW-1:0]        cm_new;

    genvar gb;
    generate
        for (gb = 0; gb < AW; gb++) begin : g_mask
            if (gb < MASK_W) begin : g_in
                assign mask_ext[gb] = i_mask[gb];
            end else begin : g_zero
                assign mask_ext[gb] = 1'b0;
            end
        end
    endgenerate

    assign o_q_ready     = (r_state == S_IDLE);
    assign o_valid       = r_out_v;
    assign o_expectation = r_out;

    // sweep index: pair ops insert a zero at the target bit
    always_comb begin
        pair   = (r_op == ACT_H) || (r_op == ACT_CX);
        c_pair = r_cnt[CW-1:1];
        m_lo   = r_m - AW'(1);
        low    = c_pair & m_lo;
        high   = (c_pair & ~m_lo) << 1;
        idx_i  = pair ? (high | low) : r_cnt[AW-1:0];
        idx_j  = idx_i | r_m;
        issue  = (r_state == S_SWEEP) && (r_cnt < r_total) && (!pair || !r_cnt[0]);
        case (r_op)
            ACT_RZ:   bit_i = (idx_i & r_m) != '0;
            ACT_CX:   bit_i = (idx_i & r_cm) != '0;
            ACT_MEAS: bit_i = ^(idx_i & mask_ext);
            default:  bit_i = 1'b0;
        endcase
    end

    // one cordic micro-rotation, plus the qubit masks of the queued item
    always_comb begin
        dx = r_y >>> r_step;
        dy = r_x >>> r_step;
        tz = atan_step(r_step);
        if (r_z >= 0) begin
            nx = r_x - dx;
            ny = r_y + dy;
            nz = r_z - tz;
        end else begin
            nx = r_x + dx;
            ny = r_y - dy;
            nz = r_z + tz;
        end
        m_new  = AW'(1) << i_q_entry.q0;
        cm_new = AW'(1) << i_q_entry.q0;
        if (i_q_entry.op == ACT_CX) begin
            m_new = AW'(1) << i_q_entry.q1;
        end
    end

    // stage 1: multiplier operands from read data
    always_comb begin
        xr = r_rd0[DW-1:AMP_W];
        xi = r_rd0[AMP_W-1:0];
        yr = r_rd1[DW-1:AMP_W];
        yi = r_rd1[AMP_W-1:0];
        sg = r_p1_b ? r_s : -r_s;
        ma_a = '0; mb_a = '0; ma_b = '0; mb_b = '0;
        ma_c = '0; mb_c = '0; ma_d = '0; mb_d = '0;
        case (r_op)
            ACT_H: begin
                ma_a = ZW'(19'(xr) + 19'(yr)); mb_a = HALF_SQRT;
                ma_b = ZW'(19'(xi) + 19'(yi)); mb_b = HALF_SQRT;
                ma_c = ZW'(19'(xr) - 19'(yr)); mb_c = HALF_SQRT;
                ma_d = ZW'(19'(xi) - 19'(yi)); mb_d = HALF_SQRT;
            end
            ACT_RZ: begin
                ma_a = ZW'(xr); mb_a = r_c;
                ma_b = ZW'(xi); mb_b = sg;
                ma_c = ZW'(xr); mb_c = sg;
                ma_d = ZW'(xi); mb_d = r_c;
            end
            ACT_MEAS: begin
                ma_a = ZW'(xr); mb_a = ZW'(xr);
                ma_b = ZW'(xi); mb_b = ZW'(xi);
            end
            default: begin
                ma_a = '0;
            end
        endcase
        pr_a = ma_a * mb_a;
        pr_b = ma_b * mb_b;
        pr_c = ma_c * mb_c;
        pr_d = ma_d * mb_d;
    end

    // stage 2: round, saturate, pick write data and the measure accumulator terms
    always_comb begin
        wi = {rnd_sat(r_pa), rnd_sat(r_pb)};
        wj = {rnd_sat(r_pc), rnd_sat(r_pd)};
        case (r_op)
            ACT_RZ: wi = {rnd_sat(r_pa - r_pb), rnd_sat(r_pc + r_pd)};
            ACT_CX: begin
                wi = r_p2_b ? r_sw1 : r_sw0;
                wj = r_p2_b ? r_sw0 : r_sw1;
            end
            default: wi = wi;
        endcase
        pw_sum  = r_pa + r_pb;
        acc_add = r_p2_b ? -ACW'(pw_sum) : ACW'(pw_sum);
        acc_rnd = (r_acc + $signed(ACW'(8))) >>> 4;
    end

    always_comb begin
        we = 1'b0;
        wa = r_p2_i;
        wd = wi;
        if (r_state == S_CLEAR) begin
            we = 1'b1;
            wa = r_cnt[AW-1:0];
            wd = (r_cnt[AW-1:0] == '0) ? {AMP_MAX, AMP_W'(0)} : '0;
        end else if (r_p3_v) begin
            we = 1'b1;
            wa = r_p3_j;
            wd = r_p3_d;
        end else if (r_p2_v && (r_op != ACT_MEAS)) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd0 <= r_mem[idx_i];
            r_rd1 <= r_mem[idx_j];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p1_i <= idx_i;
        r_p1_j <= idx_j;
        r_p1_b <= bit_i;
        r_p2_i <= r_p1_i;
        r_p2_j <= r_p1_j;
        r_p2_b <= r_p1_b;
        if (r_p1_v) begin
            r_pa  <= pr_a[PW-1:0];
            r_pb  <= pr_b[PW-1:0];
            r_pc  <= pr_c[PW-1:0];
            r_pd  <= pr_d[PW-1:0];
            r_sw0 <= r_rd0;
            r_sw1 <= r_rd1;
        end
        r_p3_j <= r_p2_j;
        r_p3_d <= wj;
        if (r_state == S_CORDIC) begin
            r_x    <= nx;
            r_y    <= ny;
            r_z    <= nz;
            r_step <= r_step + 1'b1;
            r_c    <= r_neg ? -nx : nx;
            r_s    <= r_neg ? -ny : ny;
        end
        if (r_state == S_IDLE && i_q_valid) begin
            r_op    <= i_q_entry.op;
            r_m     <= m_new;
            r_cm    <= cm_new;
            r_x     <= CORDIC_GAIN;
            r_y     <= '0;
            r_z     <= i_q_entry.h;
            r_neg   <= i_q_entry.neg;
            r_step  <= '0;
            r_total <= CW'(1) << i_n;
            r_acc   <= '0;
        end else if (r_p2_v && r_op == ACT_MEAS) begin
            r_acc <= r_acc + acc_add;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v && pair;
            if (r_state == S_RESULT && (!r_out_v || i_ready)) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[AW-1:0] == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_q_valid) begin
                        case (i_q_entry.op)
                            ACT_START: r_state <= S_CLEAR;
                            ACT_RZ:    r_state <= S_CORDIC;
                            default:   r_state <= S_SWEEP;
                        endcase
                    end
                end
                S_CORDIC: begin
                    if (r_step == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_cnt < r_total) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_v && !r_p2_v && !r_p3_v) begin
                        r_state <= (r_op == ACT_MEAS) ? S_RESULT : S_IDLE;
                    end
                end
                S_RESULT: begin
                    if (!r_out_v || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && (!r_out_v || i_ready)) begin
            if (acc_rnd > ACW'(EXP_ONE))
                r_out <= EXP_ONE;
            else if (acc_rnd < -ACW'(EXP_ONE))
                r_out <= -EXP_ONE;
            else
                r_out <= acc_rnd[EXP_W-1:0];
        end
    end

endmodule

@@ rtl/core/quantum_statevector_gate_engine.sv @@
// quantum_statevector_gate_engine: top level, configuration registers and block wiring
// depends on qsg_pkg, qsg_front, qsg_queue, qsg_back
//
// usage: items enter on i_valid/o_ready with action, qubits and rz angle; a measure
// item returns one beat on o_valid/i_ready carrying the q1.30 expectation, all other
// actions return nothing. configuration is a plain write port (i_cfg_we, index, data),
// to be used only while the engine is idle; the block itself does not enforce this.
// throughput: the engine runs one item at a time from a two-deep queue; rz runs the
// cordic rotation before its sweep, start reruns the clearing pass and a measure adds
// the result handoff. the sweep rate is set by the single write port of the amplitude
// memory: at most one entry written per cycle. items that change nothing (bad qubit,
// unused code) are dropped by the front.
// reset: registers return to 10 qubits and an empty mask, then a clearing pass over all
// 2^MAX_QUBITS entries sets the store to the all-zero basis state; o_ready drops once
// the queue and the front register are full during that pass.
// stall: a result waiting on i_ready holds the engine before its next measure result,
// while the front keeps taking items into the queue.
module quantum_statevector_gate_engine import qsg_pkg::*; #(
    parameter int MAX_QUBITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2:0]              i_action,
    input  logic [QIDX_W-1:0]       i_first_qubit,
    input  logic [QIDX_W-1:0]       i_second_qubit,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [EXP_W-1:0] o_expectation,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data
);

    localparam int NW = $clog2(MAX_QUBITS + 1);

    logic [3:0]        r_qubit_count;
    logic [MASK_W-1:0] r_observable_mask;
    logic [NW-1:0]     n_used;
    t_push             push;
    logic              push_ready;
    logic              q_valid, q_ready;
    t_entry            q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubit_count     <= 4'd10;
            r_observable_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUBIT_COUNT: r_qubit_count     <= i_cfg_data[3:0];
                CFG_OBS_MASK:    r_observable_mask <= i_cfg_data;
                default:         r_qubit_count     <= r_qubit_count;
            endcase
        end
    end

    always_comb begin
        if (r_qubit_count == '0)
            n_used = NW'(1);
        else if (32'(r_qubit_count) > MAX_QUBITS)
            n_used = NW'(MAX_QUBITS);
        else
            n_used = NW'(r_qubit_count);
    end

    qsg_front #(.MAX_QUBITS(MAX_QUBITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_first_qubit  (i_first_qubit),
        .i_second_qubit (i_second_qubit),
        .i_angle        (i_angle),
        .i_n            (n_used),
        .o_push         (push),
        .i_push_ready   (push_ready)
    );

    qsg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_pop_valid  (q_valid),
        .o_pop_entry  (q_entry),
        .i_pop_ready  (q_ready)
    );

    qsg_back #(.MAX_QUBITS(MAX_QUBITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_n           (n_used),
        .i_mask        (r_observable_mask),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_q_ready     (q_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_expectation (o_expectation)
    );

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for the state-vector gate engine
// depends on qsg_pkg and quantum_statevector_gate_engine; keeps its own amplitude store
`timescale 1ns / 1ps

module tb_top;
    import qsg_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int DRAIN_CYCLES = 6000;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam longint INV_SQRT2 = 11863283;
    localparam longint GAIN_Q24 = 10188014;
    localparam longint PI_Q = 52707179;
    localparam longint HALF_PI_Q = 26353589;
    localparam longint ONE_Q30 = 1073741824;
    localparam longint ARCTAN_Q24 [9] = '{13176795, 7778716, 4110060, 2086331, 1047214,
                                         524117, 262123, 131069, 65536};

    typedef struct {
        logic [2:0]               act;
        logic [QIDX_W-1:0]        q0;
        logic [QIDX_W-1:0]        q1;
        logic signed [ANGLE_W-1:0] ang;
    } t_gate_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [2:0] i_action = '0;
    logic [QIDX_W-1:0] i_first_qubit = '0;
    logic [QIDX_W-1:0] i_second_qubit = '0;
    logic signed [ANGLE_W-1:0] i_angle = '0;
    logic o_valid;
    logic i_ready = 1'b1;
    logic signed [EXP_W-1:0] o_expectation;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    quantum_statevector_gate_engine u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model state
    int amp_re [STORE_DEPTH];
    int amp_im [STORE_DEPTH];
    logic [3:0] qubits_reg;
    logic [9:0] obs_mask_reg;

    t_gate_item pending_items[$];
    logic signed [EXP_W-1:0] expected_expectations[$];
    int mismatch_count = 0;
    bit no_idle = 0;
    bit in_fire = 0, out_fire = 0;
    int send_gap = 0, ready_stall = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int sat_amp(input longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return int'(v);
    endfunction

    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic void clear_amplitudes();
        for (int i = 0; i < STORE_DEPTH; i++) begin
            amp_re[i] = 0;
            amp_im[i] = 0;
        end
        amp_re[0] = 131071;
    endfunction

    function automatic int active_qubits();
        if (qubits_reg == 0) return 1;
        if (qubits_reg > 10) return 10;
        return int'(qubits_reg);
    endfunction

    function automatic void apply_hadamard(input int size, input int m);
        longint xr, xi, yr, yi;
        int j;
        for (int i = 0; i < size; i++) begin
            if ((i & m) == 0) begin
                j = i | m;
                xr = amp_re[i]; xi = amp_im[i];
                yr = amp_re[j]; yi = amp_im[j];
                amp_re[i] = sat_amp(rnd_shift((xr + yr) * INV_SQRT2, 24));
                amp_im[i] = sat_amp(rnd_shift((xi + yi) * INV_SQRT2, 24));
                amp_re[j] = sat_amp(rnd_shift((xr - yr) * INV_SQRT2, 24));
                amp_im[j] = sat_amp(rnd_shift((xi - yi) * INV_SQRT2, 24));
            end
        end
    endfunction

    function automatic void rotate_z_phase(input int size, input int m,
                                           input logic signed [ANGLE_W-1:0] ang);
        longint h, x, y, z, t, dx, dy, c, s, sg, re, im;
        bit flip;
        h = longint'(ang) * 512;
        flip = 0;
        if (h > HALF_PI_Q) begin
            h -= PI_Q; flip = 1;
        end else if (h < -HALF_PI_Q) begin
            h += PI_Q; flip = 1;
        end
        x = GAIN_Q24; y = 0; z = h;
        for (int i = 0; i < 24; i++) begin
            t = (i < 9) ? ARCTAN_Q24[i] : (longint'(1) << (24 - i));
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= t;
            end else begin
                x += dx; y -= dy; z += t;
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        for (int i = 0; i < size; i++) begin
            re = amp_re[i]; im = amp_im[i];
            sg = (i & m) ? s : -s;
            amp_re[i] = sat_amp(rnd_shift(re * c - im * sg, 24));
            amp_im[i] = sat_amp(rnd_shift(re * sg + im * c, 24));
        end
    endfunction

    function automatic void apply_cnot(input int size, input int cm, input int tm);
        int r, q, j;
        for (int i = 0; i < size; i++) begin
            if ((i & cm) != 0 && (i & tm) == 0) begin
                j = i | tm;
                r = amp_re[i]; q = amp_im[i];
                amp_re[i] = amp_re[j]; amp_im[i] = amp_im[j];
                amp_re[j] = r; amp_im[j] = q;
            end
        end
    endfunction

    function automatic logic signed [EXP_W-1:0] z_expectation(input int size);
        longint acc, p;
        acc = 0;
        for (int i = 0; i < size; i++) begin
            p = longint'(amp_re[i]) * amp_re[i] + longint'(amp_im[i]) * amp_im[i];
            acc += ($countones(i & int'(obs_mask_reg)) & 1) ? -p : p;
        end
        acc = rnd_shift(acc, 4);
        if (acc > ONE_Q30) acc = ONE_Q30;
        if (acc < -ONE_Q30) acc = -ONE_Q30;
        return acc[EXP_W-1:0];
    endfunction

    function automatic void advance_state(input t_gate_item it);
        int n, size;
        n = active_qubits();
        size = 1 << n;
        case (it.act)
            ACT_START: clear_amplitudes();
            ACT_H:     if (it.q0 < n) apply_hadamard(size, 1 << it.q0);
            ACT_RZ:    if (it.q0 < n) rotate_z_phase(size, 1 << it.q0, it.ang);
            ACT_CX:    if (it.q0 < n && it.q1 < n) apply_cnot(size, 1 << it.q0, 1 << it.q1);
            ACT_MEAS:  expected_expectations.push_back(z_expectation(size));
            default: ;
        endcase
    endfunction

    // accept and check at the rising edge
    always @(posedge i_clk) begin
        t_gate_item it;
        in_fire <= i_rst_n && i_valid && o_ready;
        out_fire <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && i_valid && o_ready) begin
            it.act = i_action; it.q0 = i_first_qubit;
            it.q1 = i_second_qubit; it.ang = i_angle;
            advance_state(it);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_expectations.size() == 0)
                report_mismatch($sformatf("unexpected result %0d", o_expectation));
            else if (o_expectation !== expected_expectations[0])
                report_mismatch($sformatf("expectation %0d, want %0d", o_expectation,
                                          expected_expectations[0]));
            if (expected_expectations.size() != 0)
                void'(expected_expectations.pop_front());
        end
    end

    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 10);
    endfunction

    // input driver, changes on the falling edge
    always @(negedge i_clk) begin
        t_gate_item it;
        if (i_rst_n && !(i_valid && !in_fire)) begin
            if (in_fire) send_gap = draw_wait();
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_valid <= 1'b1;
                i_action <= it.act;
                i_first_qubit <= it.q0;
                i_second_qubit <= it.q1;
                i_angle <= it.ang;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (out_fire) ready_stall = draw_wait();
        else if (ready_stall > 0) ready_stall--;
        i_ready <= (ready_stall == 0);
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = d;
        if (idx == CFG_QUBIT_COUNT) qubits_reg = d[3:0];
        else obs_mask_reg = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_valid || expected_expectations.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_item(input logic [2:0] a, input int q0, input int q1, input int ang);
        t_gate_item it;
        it.act = a; it.q0 = QIDX_W'(q0); it.q1 = QIDX_W'(q1); it.ang = ANGLE_W'(ang);
        pending_items.push_back(it);
    endtask

    task automatic push_random(input int count);
        int n, r, q0, q1, ang;
        logic [2:0] a;
        n = active_qubits();
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6) a = ACT_START;
            else if (r < 30) a = ACT_H;
            else if (r < 52) a = ACT_RZ;
            else if (r < 72) a = ACT_CX;
            else if (r < 95) a = ACT_MEAS;
            else a = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            // mostly in-range qubits, some out of range
            q0 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
            q1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
            r = $urandom_range(0, 9);
            ang = (r == 0) ? -131072 : (r == 1) ? 131071 : $urandom_range(0, 262143) - 131072;
            push_item(a, q0, q1, ang);
        end
    endtask

    task automatic run_phase(input int qcount, input int msk, input int count, input bit quiet);
        wait_idle();
        cfg_write(CFG_QUBIT_COUNT, CFG_DAT_W'(qcount));
        cfg_write(CFG_OBS_MASK, CFG_DAT_W'(msk));
        no_idle = quiet;
        push_random(count);
    endtask

    initial begin
        qubits_reg = 10;
        obs_mask_reg = '0;
        clear_amplitudes();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (1100) @(posedge i_clk);

        cfg_write(CFG_QUBIT_COUNT, CFG_DAT_W'(3));
        cfg_write(CFG_OBS_MASK, 10'h005);
        push_item(ACT_MEAS, 0, 0, 0);
        push_item(ACT_H, 0, 0, 0);
        push_item(ACT_H, 1, 0, 0);
        push_item(ACT_H, 2, 0, 0);
        push_item(ACT_MEAS, 0, 0, 0);
        push_item(ACT_RZ, 0, 0, 131071);
        push_item(ACT_RZ, 1, 0, -131072);
        push_item(ACT_RZ, 2, 0, 0);
        push_item(ACT_CX, 0, 1, 0);
        push_item(ACT_CX, 1, 1, 0);
        push_item(ACT_CX, 2, 15, 0);
        push_item(ACT_H, 9, 0, 0);
        push_item(ACT_H, 15, 0, 0);
        push_item(ACT_RZ, 3, 0, 25736);
        push_item(ACT_MEAS, 0, 0, 0);
        push_item(3'd5, 0, 0, 0);
        push_item(3'd6, 15, 15, -1);
        push_item(3'd7, 7, 9, 1);
        push_item(ACT_MEAS, 0, 0, 0);
        push_item(ACT_START, 0, 0, 0);
        push_item(ACT_H, 0, 0, 0);
        push_item(ACT_H, 0, 0, 0);
        push_item(ACT_MEAS, 0, 0, 0);

        run_phase(1, 10'h3ff, 60, 0);
        run_phase(0, 10'h001, 40, 1);
        run_phase(4, 10'h00a, 80, 0);
        run_phase(10, 10'h2a5, 45, 0);   // keeps upper entries from the smaller runs
        run_phase(2, 10'h000, 60, 0);
        run_phase(15, 10'h3ff, 30, 1);
        run_phase(6, 10'h15c, 100, 0);
        wait_idle();

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #10000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/qsg_pkg.sv
rtl/core/qsg_queue.sv
rtl/core/qsg_front.sv
rtl/core/qsg_back.sv
rtl/core/quantum_statevector_gate_engine.sv
bench/tb_top.sv
